// File: src/pbag_pkg.sv
package pbag_pkg;

  // Layout constants of the partitioned workspace
  localparam int unsigned ALIGN_BYTES             = 64;
  localparam int unsigned ROW_RECORD_BYTES        = 16;
  localparam int unsigned ASSIGNMENT_RECORD_BYTES = 8;
  localparam int unsigned EXPERT_QUANTUM          = 16;
  localparam int unsigned COMBINE_ELEM_BYTES      = 4;
  localparam int unsigned EXPERT_ELEM_BYTES       = 4;

  // Datapath widths, sized for the field ranges and the constants above
  localparam int unsigned PIDX_W   = 23;  // ring * num_workers + origin
  localparam int unsigned CELL_W   = 44;  // capacity * hidden, row * hidden + column
  localparam int unsigned STRIDE_W = 47;  // aligned partition stride in bytes
  localparam int unsigned REL_W    = 46;  // element offset inside a partition
  localparam int unsigned LO_W     = 24;  // low slice of the stride for the split multiply
  localparam int unsigned HI_W     = STRIDE_W - LO_W;
  localparam int unsigned PROD_W   = PIDX_W + STRIDE_W + 1;
  localparam int unsigned OFF_W    = 64;
  localparam int unsigned ECAP_W   = 17;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    MODE_HIDDEN  = 3'd0,
    MODE_ROW     = 3'd1,
    MODE_ASSIGN  = 3'd2,
    MODE_EXPERT  = 3'd3,
    MODE_PARTIAL = 3'd4,
    MODE_OUTPUT  = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_WORKERS      = 3'd0,
    CFG_NUM_RINGS        = 3'd1,
    CFG_HIDDEN_SIZE      = 3'd2,
    CFG_ROWS_PER_PART    = 3'd3,
    CFG_ASSIGNS_PER_PART = 3'd4,
    CFG_NUM_EXPERTS      = 3'd5,
    CFG_DTYPE_IS_FP32    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [6:0]  num_workers;
    logic [15:0] num_rings;
    logic [19:0] hidden_size;
    logic [23:0] rows_per_part;
    logic [23:0] assigns_per_part;
    logic [15:0] num_experts;
    logic        dtype_is_fp32;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              ok;
    logic [2:0]        mode;
    logic [23:0]       idx;
    logic [19:0]       col;
    logic [PIDX_W-1:0] pidx;
  } s1_t;

  typedef struct packed {
    logic              valid;
    logic              ok;
    logic [2:0]        mode;
    logic [23:0]       idx;
    logic [PIDX_W-1:0] pidx;
    logic [CELL_W-1:0] cells;
    logic [CELL_W-1:0] lin;
  } s2_t;

  typedef struct packed {
    logic                valid;
    logic                ok;
    logic [PIDX_W-1:0]   pidx;
    logic [STRIDE_W-1:0] stride;
    logic [REL_W-1:0]    rel;
  } s3_t;

  typedef struct packed {
    logic                     valid;
    logic                     ok;
    logic [PIDX_W+LO_W-1:0]   pp_lo;
    logic [PIDX_W+HI_W-1:0]   pp_hi;
    logic [REL_W-1:0]         rel;
  } s4_t;

  typedef struct packed {
    logic             valid;
    logic             ok;
    logic [OFF_W-1:0] base;
    logic [REL_W-1:0] rel;
  } s5_t;

endpackage

// File: src/pbag_decode.sv
module pbag_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  pbag_pkg::cfg_t    cfg,
  input  logic              in_take,
  input  logic [2:0]        mode,
  input  logic [15:0]       ring,
  input  logic [5:0]        origin,
  input  logic [23:0]       idx,
  input  logic [19:0]       col,
  output pbag_pkg::s1_t     s1_r
);

  localparam int unsigned PW = pbag_pkg::PIDX_W;

  pbag_pkg::s1_t s1_nxt;

  logic ring_ok;
  logic origin_ok;
  logic col_ok;
  logic row_ok;
  logic [PW-1:0] pidx_part;

  assign ring_ok   = ring < cfg.num_rings;
  assign origin_ok = {1'b0, origin} < cfg.num_workers;
  assign col_ok    = col < cfg.hidden_size;
  assign row_ok    = idx < cfg.rows_per_part;
  assign pidx_part = PW'(ring) * PW'(cfg.num_workers) + PW'(origin);

  always_comb begin
    s1_nxt       = '0;
    s1_nxt.valid = in_take;
    s1_nxt.mode  = mode;
    s1_nxt.idx   = idx;
    s1_nxt.col   = col;
    s1_nxt.pidx  = pidx_part;
    case (mode)
      pbag_pkg::MODE_HIDDEN, pbag_pkg::MODE_PARTIAL: begin
        s1_nxt.ok = ring_ok && origin_ok && row_ok && col_ok;
      end
      pbag_pkg::MODE_ROW: begin
        s1_nxt.ok = ring_ok && origin_ok && row_ok;
      end
      pbag_pkg::MODE_ASSIGN: begin
        s1_nxt.ok = ring_ok && origin_ok && (idx < cfg.assigns_per_part);
      end
      pbag_pkg::MODE_EXPERT: begin
        s1_nxt.ok = ring_ok && origin_ok && (idx < {8'h00, cfg.num_experts});
      end
      pbag_pkg::MODE_OUTPUT: begin
        // one partition per ring, origin ignored
        s1_nxt.ok   = ring_ok && row_ok && col_ok;
        s1_nxt.pidx = PW'(ring);
      end
      default: begin
        s1_nxt.ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
    end
  end

endmodule

// File: src/pbag_scale.sv
module pbag_scale (
  input  logic           clk,
  input  logic           rst_n,
  input  pbag_pkg::cfg_t cfg,
  input  pbag_pkg::s1_t  s1,
  output pbag_pkg::s3_t  s3_r
);

  localparam int unsigned SW = pbag_pkg::STRIDE_W;
  localparam int unsigned RW = pbag_pkg::REL_W;
  localparam int unsigned CW = pbag_pkg::CELL_W;
  localparam int unsigned EW = pbag_pkg::ECAP_W;

  pbag_pkg::s2_t s2_nxt;
  pbag_pkg::s2_t s2_r;
  pbag_pkg::s3_t s3_nxt;

  logic [EW-1:0] ecap;
  logic [SW-1:0] bytes;
  logic [SW-1:0] bytes_min;
  logic [SW-1:0] bytes_up;
  logic [RW-1:0] rel;
  logic [1:0]    dshift;

  // Stage 2: capacity * hidden and row * hidden + column
  always_comb begin
    s2_nxt.valid = s1.valid;
    s2_nxt.ok    = s1.ok;
    s2_nxt.mode  = s1.mode;
    s2_nxt.idx   = s1.idx;
    s2_nxt.pidx  = s1.pidx;
    s2_nxt.cells = CW'(cfg.rows_per_part) * CW'(cfg.hidden_size);
    s2_nxt.lin   = CW'(s1.idx) * CW'(cfg.hidden_size) + CW'(s1.col);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r <= s2_nxt;
    end
  end

  // Stage 3: region bytes, aligned stride and element offset
  assign dshift = cfg.dtype_is_fp32 ? 2'd2 : 2'd1;
  assign ecap   = EW'(((EW'(cfg.num_experts) + EW'(pbag_pkg::EXPERT_QUANTUM - 1))
                       / pbag_pkg::EXPERT_QUANTUM) * pbag_pkg::EXPERT_QUANTUM);

  always_comb begin
    case (s2_r.mode)
      pbag_pkg::MODE_HIDDEN: begin
        bytes = SW'(s2_r.cells) << dshift;
        rel   = RW'(s2_r.lin) << dshift;
      end
      pbag_pkg::MODE_ROW: begin
        bytes = SW'(cfg.rows_per_part) * SW'(pbag_pkg::ROW_RECORD_BYTES);
        rel   = RW'(s2_r.idx) * RW'(pbag_pkg::ROW_RECORD_BYTES);
      end
      pbag_pkg::MODE_ASSIGN: begin
        bytes = SW'(cfg.assigns_per_part) * SW'(pbag_pkg::ASSIGNMENT_RECORD_BYTES);
        rel   = RW'(s2_r.idx) * RW'(pbag_pkg::ASSIGNMENT_RECORD_BYTES);
      end
      pbag_pkg::MODE_EXPERT: begin
        bytes = SW'(ecap) * SW'(pbag_pkg::EXPERT_ELEM_BYTES);
        rel   = RW'(s2_r.idx) * RW'(pbag_pkg::EXPERT_ELEM_BYTES);
      end
      pbag_pkg::MODE_PARTIAL, pbag_pkg::MODE_OUTPUT: begin
        bytes = SW'(s2_r.cells) * SW'(pbag_pkg::COMBINE_ELEM_BYTES);
        rel   = RW'(s2_r.lin) * RW'(pbag_pkg::COMBINE_ELEM_BYTES);
      end
      default: begin
        bytes = '0;
        rel   = '0;
      end
    endcase
  end

  // bytes stays below 2**46, so the rounded stride fits SW bits
  assign bytes_min = (bytes < SW'(pbag_pkg::ALIGN_BYTES)) ? SW'(pbag_pkg::ALIGN_BYTES) : bytes;
  assign bytes_up  = SW'(((bytes_min + SW'(pbag_pkg::ALIGN_BYTES - 1))
                          / pbag_pkg::ALIGN_BYTES) * pbag_pkg::ALIGN_BYTES);

  always_comb begin
    s3_nxt.valid  = s2_r.valid;
    s3_nxt.ok     = s2_r.ok;
    s3_nxt.pidx   = s2_r.pidx;
    s3_nxt.stride = bytes_up;
    s3_nxt.rel    = rel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else begin
      s3_r <= s3_nxt;
    end
  end

endmodule

// File: src/pbag_base.sv
module pbag_base (
  input  logic          clk,
  input  logic          rst_n,
  input  pbag_pkg::s3_t s3,
  output pbag_pkg::s5_t s5_r
);

  localparam int unsigned PW  = pbag_pkg::PIDX_W;
  localparam int unsigned LW  = pbag_pkg::LO_W;
  localparam int unsigned HW  = pbag_pkg::HI_W;
  localparam int unsigned SUM = pbag_pkg::PROD_W;
  localparam int unsigned OW  = pbag_pkg::OFF_W;

  pbag_pkg::s4_t s4_nxt;
  pbag_pkg::s4_t s4_r;
  pbag_pkg::s5_t s5_nxt;

  logic [SUM-1:0] prod;

  // Stage 4: partition index times stride, split into two partial products
  always_comb begin
    s4_nxt.valid = s3.valid;
    s4_nxt.ok    = s3.ok;
    s4_nxt.pp_lo = (PW+LW)'(s3.pidx) * (PW+LW)'(s3.stride[LW-1:0]);
    s4_nxt.pp_hi = (PW+HW)'(s3.pidx) * (PW+HW)'(s3.stride[pbag_pkg::STRIDE_W-1:LW]);
    s4_nxt.rel   = s3.rel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.valid <= 1'b0;
    end else begin
      s4_r <= s4_nxt;
    end
  end

  // Stage 5: combine partial products, clear ok on 64-bit overflow
  assign prod = SUM'(s4_r.pp_lo) + (SUM'(s4_r.pp_hi) << LW);

  always_comb begin
    s5_nxt.valid = s4_r.valid;
    s5_nxt.ok    = s4_r.ok && !(|prod[SUM-1:OW]);
    s5_nxt.base  = prod[OW-1:0];
    s5_nxt.rel   = s4_r.rel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_r.valid <= 1'b0;
    end else begin
      s5_r <= s5_nxt;
    end
  end

endmodule

// File: src/pbag_sum.sv
module pbag_sum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pbag_pkg::s5_t                 s5,
  output logic                          out_valid_r,
  output logic                          out_ok_r,
  output logic [pbag_pkg::OFF_W-1:0]    out_offset_r
);

  localparam int unsigned OW = pbag_pkg::OFF_W;

  logic [OW:0]   total;
  logic          ok_nxt;
  logic          out_valid_nxt;
  logic [OW-1:0] out_offset_nxt;

  assign total          = (OW+1)'(s5.base) + (OW+1)'(s5.rel);
  assign ok_nxt         = s5.ok && !total[OW];
  assign out_valid_nxt  = s5.valid;
  // zero the offset of a failed transaction
  assign out_offset_nxt = ok_nxt ? total[OW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r     <= ok_nxt;
    out_offset_r <= out_offset_nxt;
  end

endmodule

// File: src/partition_buffer_address_generator.sv
// Partition buffer address generator.
// Input channel: drive in_mode, in_ring, in_origin, in_element_index and
// in_column with start high; the transaction is taken at a rising edge where
// start is high and busy is low. busy is always low, so one transaction can
// enter every cycle.
// Result channel: out_valid is high for one cycle with out_offset and out_ok;
// it is registered, as are out_offset and out_ok, and each accepted
// transaction passes through six pipeline registers on its way
// from the input ports to the result ports. Throughput is one transaction per
// cycle; the depth is set by the split 23 x 47-bit partition multiply and the
// 64-bit overflow checks that follow it. out_offset is zero when out_ok is 0.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Configuration: cfg_we writes cfg_data to register cfg_index at a clock edge;
// write only while no transaction is in the pipeline.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the
// register defaults: one worker, one ring, hidden size one, zero capacities,
// one expert, two-byte dispatch elements.
module partition_buffer_address_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_mode,
  input  logic [15:0]                       in_ring,
  input  logic [5:0]                        in_origin,
  input  logic [23:0]                       in_element_index,
  input  logic [19:0]                       in_column,
  output logic                              out_valid,
  output logic [63:0]                       out_offset,
  output logic                              out_ok,
  input  logic                              cfg_we,
  input  logic [pbag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbag_pkg::CFG_W-1:0]        cfg_data
);

  pbag_pkg::cfg_t cfg_r;
  pbag_pkg::cfg_t cfg_nxt;
  pbag_pkg::s1_t  s1;
  pbag_pkg::s3_t  s3;
  pbag_pkg::s5_t  s5;
  logic           in_take;

  assign busy    = 1'b0;
  assign in_take = start && !busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pbag_pkg::CFG_NUM_WORKERS:      cfg_nxt.num_workers      = cfg_data[6:0];
        pbag_pkg::CFG_NUM_RINGS:        cfg_nxt.num_rings        = cfg_data[15:0];
        pbag_pkg::CFG_HIDDEN_SIZE:      cfg_nxt.hidden_size      = cfg_data[19:0];
        pbag_pkg::CFG_ROWS_PER_PART:    cfg_nxt.rows_per_part    = cfg_data[23:0];
        pbag_pkg::CFG_ASSIGNS_PER_PART: cfg_nxt.assigns_per_part = cfg_data[23:0];
        pbag_pkg::CFG_NUM_EXPERTS:      cfg_nxt.num_experts      = cfg_data[15:0];
        pbag_pkg::CFG_DTYPE_IS_FP32:    cfg_nxt.dtype_is_fp32    = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_workers      <= 7'd1;
      cfg_r.num_rings        <= 16'd1;
      cfg_r.hidden_size      <= 20'd1;
      cfg_r.rows_per_part    <= '0;
      cfg_r.assigns_per_part <= '0;
      cfg_r.num_experts      <= 16'd1;
      cfg_r.dtype_is_fp32    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pbag_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_take(in_take),
    .mode   (in_mode),
    .ring   (in_ring),
    .origin (in_origin),
    .idx    (in_element_index),
    .col    (in_column),
    .s1_r   (s1)
  );

  pbag_scale u_scale (
    .clk  (clk),
    .rst_n(rst_n),
    .cfg  (cfg_r),
    .s1   (s1),
    .s3_r (s3)
  );

  pbag_base u_base (
    .clk  (clk),
    .rst_n(rst_n),
    .s3   (s3),
    .s5_r (s5)
  );

  pbag_sum u_sum (
    .clk         (clk),
    .rst_n       (rst_n),
    .s5          (s5),
    .out_valid_r (out_valid),
    .out_ok_r    (out_ok),
    .out_offset_r(out_offset)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> ##6 out_valid)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_take, 6))
    else $error("result without an accepted transaction");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_offset == '0)
    else $error("failed transaction carries a nonzero offset");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |-> $past(in_mode, 6) <= 3'(pbag_pkg::MODE_OUTPUT))
    else $error("unused mode reported ok");

endmodule
